>>> rtl/core/c2d_pkg.sv
//------------------------------------------------------------------------------
// c2d_pkg: shared types and constants for the 2D convolution MAC unit
// Field structs, store geometry and action codes.
//------------------------------------------------------------------------------
package c2d_pkg;

  localparam int InChannels  = 4;
  localparam int InHeight    = 16;
  localparam int InWidth     = 16;
  localparam int OutChannels = 4;
  localparam int KernelSize  = 3;
  localparam int DataWidth   = 16;
  localparam int SumWidth    = 40;

  localparam int FeatDepth = InChannels * InHeight * InWidth;
  localparam int WgtDepth  = OutChannels * InChannels * KernelSize * KernelSize;
  localparam int FeatAw    = $clog2(FeatDepth);
  localparam int WgtAw     = $clog2(WgtDepth);
  localparam int ProdWidth = 2 * DataWidth;
  localparam int QDepth    = 2;

  typedef enum logic [1:0] {
    ACT_LOAD_FEAT = 2'd0,
    ACT_LOAD_WGT  = 2'd1,
    ACT_COMPUTE   = 2'd2,
    ACT_NONE      = 2'd3
  } action_t;

  localparam logic [0:0] REG_STRIDE  = 1'b0;
  localparam logic [0:0] REG_PADDING = 1'b1;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         out_channel;
    logic [1:0]         in_channel;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [SumWidth-1:0] sum;
    logic [1:0]                 out_channel_echo;
    logic [3:0]                 out_row;
    logic [3:0]                 out_col;
  } out_item_t;

  // Compute job handed from front to back: base input coordinates.
  typedef struct packed {
    logic [1:0]        oc;
    logic [3:0]        row;
    logic [3:0]        col;
    logic signed [7:0] y0;
    logic signed [7:0] x0;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN,
    BK_DONE
  } bk_state_t;

endpackage

>>> rtl/core/conv2d_multichannel_mac_unit.sv
//------------------------------------------------------------------------------
// conv2d_multichannel_mac_unit: direct multi-channel 2D convolution layer
// Loads features and weights, computes one output position per compute word.
//------------------------------------------------------------------------------
// Usage: push input words while full is low. A feature or weight load is
// written to its store in the cycle it is taken and yields no result; full
// holds a load off while any compute is queued or running, so a compute
// always sees the stores as they were when it was pushed. A compute word
// is range checked and queued (two deep) for the back end, which walks
// 4 channels x 9 taps through one multiplier, one tap a cycle.
// A compute taken by an idle unit goes through hand-off, the tap walk,
// pipeline drain and capture of the result before empty drops. The back
// end takes the next compute only once the last result is captured, as
// all taps share the single multiply-accumulate. Results are held
// until pop; the back end stalls while its result waits, and the queue
// then fills and raises full. Reset clears the queue, sequencer and result
// flag, sets stride 1 and padding 0; store contents are undefined until
// written. Write stride and padding only while idle.
//------------------------------------------------------------------------------
module conv2d_multichannel_mac_unit
  import c2d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  in_item_t   in_item,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [2:0] cfg_data
);

  logic [2:0] stride;
  logic [1:0] padding;

  logic                 feat_we;
  logic [FeatAw-1:0]    feat_waddr;
  logic [FeatAw-1:0]    feat_raddr;
  logic [DataWidth-1:0] feat_rdata;
  logic                 wgt_we;
  logic [WgtAw-1:0]     wgt_waddr;
  logic [WgtAw-1:0]     wgt_raddr;
  logic [DataWidth-1:0] wgt_rdata;
  logic [DataWidth-1:0] wdata;
  logic                 job_valid;
  logic                 job_take;
  logic                 back_busy;
  job_t                 job;

  always_ff @(posedge clk) begin
    if (rst) begin
      stride  <= 3'd1;
      padding <= 2'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STRIDE:  stride  <= cfg_data;
        REG_PADDING: padding <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  c2d_front u_front (
    .clk, .rst, .push, .full, .item(in_item), .stride, .padding,
    .busy(back_busy),
    .feat_we, .feat_waddr, .wgt_we, .wgt_waddr, .wdata,
    .job_valid, .job, .job_take
  );

  c2d_ram #(.Width(DataWidth), .Depth(FeatDepth)) u_feat (
    .clk, .we(feat_we), .waddr(feat_waddr), .wdata,
    .raddr(feat_raddr), .rdata(feat_rdata)
  );

  c2d_ram #(.Width(DataWidth), .Depth(WgtDepth)) u_wgt (
    .clk, .we(wgt_we), .waddr(wgt_waddr), .wdata,
    .raddr(wgt_raddr), .rdata(wgt_rdata)
  );

  c2d_back u_back (
    .clk, .rst, .job_valid, .job, .job_take, .busy(back_busy),
    .feat_raddr, .feat_rdata, .wgt_raddr, .wgt_rdata,
    .empty, .pop, .result(out_item)
  );

endmodule

>>> rtl/core/c2d_ram.sv
//------------------------------------------------------------------------------
// c2d_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
//------------------------------------------------------------------------------
module c2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/c2d_front.sv
//------------------------------------------------------------------------------
// c2d_front: input decode and job queue
// Writes loads straight into the stores, range-checks computes and queues them.
//------------------------------------------------------------------------------
module c2d_front
  import c2d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             item,
  input  logic [2:0]           stride,
  input  logic [1:0]           padding,
  input  logic                 busy,
  output logic                 feat_we,
  output logic [FeatAw-1:0]    feat_waddr,
  output logic                 wgt_we,
  output logic [WgtAw-1:0]     wgt_waddr,
  output logic [DataWidth-1:0] wdata,
  output logic                 job_valid,
  output job_t                 job,
  input  logic                 job_take
);

  job_t       q [QDepth];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;

  logic       acc;
  logic       is_load;
  logic [2:0] st;
  logic [8:0] span_h;
  logic [8:0] span_w;
  logic [7:0] y_base;
  logic [7:0] x_base;
  logic       job_ok;
  logic       enq;

  assign is_load = (item.action == ACT_LOAD_FEAT) || (item.action == ACT_LOAD_WGT);
  // Hold loads until every queued and running compute has read the stores.
  assign full = (count == 2'(QDepth)) || (is_load && ((count != 2'd0) || busy));
  assign acc  = push && !full;
  assign st   = (stride == 3'd0) ? 3'd1 : stride;

  assign span_h = 9'(InHeight) + {6'd0, padding, 1'b0} - 9'(KernelSize);
  assign span_w = 9'(InWidth) + {6'd0, padding, 1'b0} - 9'(KernelSize);

  assign y_base = 8'({4'd0, item.row} * {5'd0, st}) - {6'd0, padding};
  assign x_base = 8'({4'd0, item.col} * {5'd0, st}) - {6'd0, padding};

  // An output position exists while position*stride stays within the padded span.
  assign job_ok = (32'(item.out_channel) < OutChannels)
               && !span_h[8] && (({5'd0, item.row} * {6'd0, st}) <= span_h)
               && !span_w[8] && (({5'd0, item.col} * {6'd0, st}) <= span_w);
  assign enq = acc && (item.action == ACT_COMPUTE) && job_ok;

  assign wdata = item.value[DataWidth-1:0];
  assign feat_we = acc && (item.action == ACT_LOAD_FEAT)
                && (32'(item.in_channel) < InChannels)
                && (32'(item.row) < InHeight) && (32'(item.col) < InWidth);
  assign feat_waddr = FeatAw'((32'(item.in_channel) * InHeight + 32'(item.row))
                      * InWidth + 32'(item.col));
  assign wgt_we = acc && (item.action == ACT_LOAD_WGT)
               && (32'(item.out_channel) < OutChannels)
               && (32'(item.in_channel) < InChannels)
               && (32'(item.row) < KernelSize) && (32'(item.col) < KernelSize);
  assign wgt_waddr = WgtAw'(((32'(item.out_channel) * InChannels + 32'(item.in_channel))
                     * KernelSize + 32'(item.row)) * KernelSize + 32'(item.col));

  assign job_valid = (count != 2'd0);
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (enq) begin
      q[wr_ptr] <= '{oc: item.out_channel, row: item.row, col: item.col,
                     y0: y_base, x0: x_base};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, enq} - {1'b0, job_take};
    end
  end

endmodule

>>> rtl/core/c2d_back.sv
//------------------------------------------------------------------------------
// c2d_back: tap sequencer and shared multiply-accumulate
// Walks channels x kernel taps, one read a cycle, and holds the result.
//------------------------------------------------------------------------------
module c2d_back
  import c2d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  job_t                 job,
  output logic                 job_take,
  output logic                 busy,
  output logic [FeatAw-1:0]    feat_raddr,
  input  logic [DataWidth-1:0] feat_rdata,
  output logic [WgtAw-1:0]     wgt_raddr,
  input  logic [DataWidth-1:0] wgt_rdata,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            result
);

  localparam int ChW = $clog2(InChannels) > 0 ? $clog2(InChannels) : 1;
  localparam int KW  = $clog2(KernelSize) > 0 ? $clog2(KernelSize) : 1;

  bk_state_t state;
  bk_state_t state_next;

  job_t       cur;
  logic [ChW-1:0] ch;
  logic [KW-1:0]  ki;
  logic [KW-1:0]  kj;
  logic       last;
  logic signed [8:0] y;
  logic signed [8:0] x;
  logic       inside_tap;

  // Pipeline: read (addr) -> data (valid1) -> product (valid2) -> accumulate
  logic       v1;
  logic       in1;
  logic       v2;
  logic signed [ProdWidth-1:0] prod;
  logic signed [SumWidth-1:0]  accum;
  logic       out_full;

  assign last = (32'(ch) == InChannels - 1) && (32'(ki) == KernelSize - 1)
             && (32'(kj) == KernelSize - 1);
  assign y = 9'(signed'(cur.y0)) + 9'(ki);
  assign x = 9'(signed'(cur.x0)) + 9'(kj);
  assign inside_tap = (y >= 0) && (y < 9'(InHeight)) && (x >= 0) && (x < 9'(InWidth));

  assign feat_raddr = FeatAw'((32'(ch) * InHeight + 32'(y[7:0])) * InWidth
                      + 32'(x[7:0]));
  assign wgt_raddr = WgtAw'(((32'(cur.oc) * InChannels + 32'(ch)) * KernelSize
                     + 32'(ki)) * KernelSize + 32'(kj));

  assign empty = !out_full;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:  if (job_valid) state_next = BK_RUN;
      BK_RUN:   if (last) state_next = BK_DRAIN;
      BK_DRAIN: if (!v1 && !v2) state_next = BK_DONE;
      BK_DONE:  if (!out_full) state_next = BK_IDLE;
      default:  state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    job_take = (state == BK_IDLE) && job_valid;
    busy     = (state != BK_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      v1       <= 1'b0;
      v2       <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= (state == BK_RUN);
      v2    <= v1;
      if (state == BK_DONE && !out_full) begin
        out_full <= 1'b1;
      end else if (pop && out_full) begin
        out_full <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    in1 <= inside_tap;
    if (job_take) begin
      cur   <= job;
      ch    <= '0;
      ki    <= '0;
      kj    <= '0;
      accum <= '0;
    end else if (state == BK_RUN) begin
      // advance tap counters
      if (32'(kj) == KernelSize - 1) begin
        kj <= '0;
        if (32'(ki) == KernelSize - 1) begin
          ki <= '0;
          ch <= ch + ChW'(1);
        end else begin
          ki <= ki + KW'(1);
        end
      end else begin
        kj <= kj + KW'(1);
      end
    end
    if (v1) begin
      if (in1) begin
        prod <= signed'(feat_rdata) * signed'(wgt_rdata);
      end else begin
        prod <= '0;
      end
    end
    if (v2) begin
      accum <= accum + SumWidth'(prod);
    end
    if (state == BK_DONE && !out_full) begin
      result <= '{sum: accum, out_channel_echo: cur.oc, out_row: cur.row,
                  out_col: cur.col};
    end
  end

endmodule

>>> verif/conv2d_multichannel_mac_unit_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// conv2d_multichannel_mac_unit_tb: self-checking bench for the conv MAC unit
// Loads feature maps and kernels, requests output positions over several
// stride and padding settings, and compares every result word against a
// local convolution model. Both handshakes see random gaps, but for one setting.
//------------------------------------------------------------------------------
module conv2d_multichannel_mac_unit_tb;
  import c2d_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  in_item_t   in_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  out_item_t  out_item;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_STRIDE;
  logic [2:0] cfg_data = '0;

  conv2d_multichannel_mac_unit i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .empty(empty), .pop(pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the stores and configuration.
  logic signed [15:0] feat_mem [FeatDepth];
  logic signed [15:0] wgt_mem [WgtDepth];
  bit feat_valid [FeatDepth];
  bit wgt_valid [WgtDepth];
  int unsigned conv_stride = 1;
  int unsigned conv_pad = 0;

  out_item_t  pending_sums [$];
  int         n_errors = 0;
  bit         idle_push = 1'b1;
  bit         idle_pop = 1'b1;

  task automatic report_mismatch(input string what);
    n_errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int out_dim(input int in_dim);
    int st;
    int span;
    st = (conv_stride == 0) ? 1 : conv_stride;
    span = in_dim + 2 * int'(conv_pad) - KernelSize;
    return (span < 0) ? 0 : span / st + 1;
  endfunction

  // Apply one word to the local model; queue the expected result if any.
  task automatic model_word(input in_item_t w);
    int st;
    int y;
    int x;
    logic signed [SumWidth-1:0] acc;
    out_item_t r;
    st = (conv_stride == 0) ? 1 : conv_stride;
    case (action_t'(w.action))
      ACT_LOAD_FEAT: begin
        feat_mem[(w.in_channel * InHeight + w.row) * InWidth + w.col] = w.value;
        feat_valid[(w.in_channel * InHeight + w.row) * InWidth + w.col] = 1'b1;
      end
      ACT_LOAD_WGT: begin
        if (w.row < KernelSize && w.col < KernelSize) begin
          wgt_mem[((w.out_channel * InChannels + w.in_channel) * KernelSize + w.row)
                  * KernelSize + w.col] = w.value;
          wgt_valid[((w.out_channel * InChannels + w.in_channel) * KernelSize + w.row)
                    * KernelSize + w.col] = 1'b1;
        end
      end
      ACT_COMPUTE: begin
        if (w.row < out_dim(InHeight) && w.col < out_dim(InWidth)) begin
          acc = '0;
          for (int ch = 0; ch < InChannels; ch++)
            for (int i = 0; i < KernelSize; i++)
              for (int j = 0; j < KernelSize; j++) begin
                y = st * w.row + i - int'(conv_pad);
                x = st * w.col + j - int'(conv_pad);
                if (y >= 0 && y < InHeight && x >= 0 && x < InWidth)
                  acc += SumWidth'(feat_mem[(ch * InHeight + y) * InWidth + x])
                         * SumWidth'(wgt_mem[((w.out_channel * InChannels + ch)
                                              * KernelSize + i) * KernelSize + j]);
              end
          r.sum = acc;
          r.out_channel_echo = w.out_channel;
          r.out_row = w.row;
          r.out_col = w.col;
          pending_sums.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // Result side: random pop stalls, check at the rising edge.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && pop && !empty) begin
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result %p", out_item));
      end else begin
        e = pending_sums.pop_front();
        if (out_item.sum !== e.sum)
          report_mismatch($sformatf("sum %0d, want %0d", out_item.sum, e.sum));
        if (out_item.out_channel_echo !== e.out_channel_echo)
          report_mismatch($sformatf("channel %0d, want %0d",
                                    out_item.out_channel_echo, e.out_channel_echo));
        if (out_item.out_row !== e.out_row)
          report_mismatch($sformatf("row %0d, want %0d", out_item.out_row, e.out_row));
        if (out_item.out_col !== e.out_col)
          report_mismatch($sformatf("col %0d, want %0d", out_item.out_col, e.out_col));
      end
    end
  end

  always @(negedge clk)
    pop <= idle_pop ? ($urandom_range(99) >= 26) : 1'b1;

  // Push stays high on return; the next word or an idle step drops it.
  task automatic send_word(input in_item_t w);
    while (idle_push && $urandom_range(99) < 26) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    model_word(w);
    @(negedge clk);
  endtask

  task automatic drain_and_config(input int unsigned st, input int unsigned pad);
    push <= 1'b0;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_STRIDE;
    cfg_data <= st[2:0];
    @(negedge clk);
    cfg_index <= REG_PADDING;
    cfg_data <= pad[2:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    conv_stride = st;
    conv_pad = pad[1:0];
  endtask

  function automatic in_item_t mk(input action_t a, input int oc, input int ic,
                                  input int r, input int c, input int v);
    in_item_t w;
    w.action = a;
    w.out_channel = oc[1:0];
    w.in_channel = ic[1:0];
    w.row = r[3:0];
    w.col = c[3:0];
    w.value = v[15:0];
    return w;
  endfunction

  // Random word; computes only touch written store entries.
  function automatic in_item_t rand_word();
    in_item_t w;
    int sel;
    int st;
    int y;
    int x;
    bit all_ok;
    sel = $urandom_range(99);
    w = in_item_t'($urandom);
    w.value = 16'($urandom);
    if ($urandom_range(3) == 0)
      w.value = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    if (sel < 35) w.action = ACT_LOAD_FEAT;
    else if (sel < 55) w.action = ACT_LOAD_WGT;
    else if (sel < 95) w.action = ACT_COMPUTE;
    else w.action = ACT_NONE;
    if (w.action == ACT_LOAD_WGT && $urandom_range(3) != 0) begin
      w.row = 4'($urandom_range(KernelSize - 1));
      w.col = 4'($urandom_range(KernelSize - 1));
    end
    if (w.action == ACT_COMPUTE) begin
      if ($urandom_range(3) != 0) begin
        w.row = 4'($urandom_range(out_dim(InHeight) - 1));
        w.col = 4'($urandom_range(out_dim(InWidth) - 1));
      end
      all_ok = 1'b1;
      for (int k = 0; k < InChannels * KernelSize * KernelSize; k++)
        if (!wgt_valid[w.out_channel * InChannels * KernelSize * KernelSize + k])
          all_ok = 1'b0;
      if (w.row < out_dim(InHeight) && w.col < out_dim(InWidth)) begin
        st = (conv_stride == 0) ? 1 : conv_stride;
        for (int ch = 0; ch < InChannels; ch++)
          for (int i = 0; i < KernelSize; i++)
            for (int j = 0; j < KernelSize; j++) begin
              y = st * w.row + i - int'(conv_pad);
              x = st * w.col + j - int'(conv_pad);
              if (y >= 0 && y < InHeight && x >= 0 && x < InWidth
                  && !feat_valid[(ch * InHeight + y) * InWidth + x])
                all_ok = 1'b0;
            end
      end
      if (!all_ok) w.action = ACT_NONE;
    end
    return w;
  endfunction

  // Directed rows: fill stores with extremes, then hit corners and range edges.
  typedef struct {
    in_item_t word;
    bit       has_sum;
    logic signed [SumWidth-1:0] sum;
  } stim_row_t;

  stim_row_t directed [$];

  initial begin
    int unsigned cfgs [6][2] = '{'{1, 0}, '{4, 2}, '{2, 1}, '{3, 2}, '{1, 2}, '{4, 0}};
    for (int i = 0; i < FeatDepth; i++) begin
      feat_valid[i] = 1'b0;
      feat_mem[i] = '0;
    end
    for (int i = 0; i < WgtDepth; i++) begin
      wgt_valid[i] = 1'b0;
      wgt_mem[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Fill the top-left 8x8 of every feature map and every weight.
    for (int i = 0; i < InChannels * 64; i++)
      send_word(mk(ACT_LOAD_FEAT, 0, i / 64, (i / 8) % 8, i % 8,
                   (i % 7 == 0) ? -32768 : (i % 5 == 0 ? 32767 : $urandom)));
    for (int i = 0; i < WgtDepth; i++)
      send_word(mk(ACT_LOAD_WGT, i / 36, (i / 9) % 4, (i / 3) % 3, i % 3,
                   (i % 2) ? 32767 : -32768));

    directed.push_back('{mk(ACT_COMPUTE, 0, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(ACT_COMPUTE, 3, 0, 5, 5, 0), 0, 0});
    directed.push_back('{mk(ACT_COMPUTE, 1, 0, 14, 0, 0), 0, 0});   // row off the map
    directed.push_back('{mk(ACT_COMPUTE, 2, 0, 0, 15, 0), 0, 0});   // col off the map
    directed.push_back('{mk(ACT_LOAD_WGT, 0, 0, 3, 0, 5), 0, 0});   // kernel row ignored
    directed.push_back('{mk(ACT_LOAD_WGT, 0, 0, 0, 15, 5), 0, 0});  // kernel col ignored
    directed.push_back('{mk(ACT_NONE, 3, 3, 15, 15, -1), 0, 0});
    directed.push_back('{mk(ACT_LOAD_FEAT, 3, 3, 7, 7, -32768), 0, 0});
    directed.push_back('{mk(ACT_COMPUTE, 3, 0, 5, 5, 0), 0, 0});
    foreach (directed[i]) send_word(directed[i].word);

    // Zero every kernel of output channel 0 for a known-zero sum.
    for (int i = 0; i < 36; i++)
      send_word(mk(ACT_LOAD_WGT, 0, i / 9, (i / 3) % 3, i % 3, 0));
    send_word(mk(ACT_COMPUTE, 0, 0, 5, 5, 0));
    if (pending_sums[$].sum !== 0) report_mismatch("zero kernel sum");

    for (int p = 0; p < 6; p++) begin
      drain_and_config(cfgs[p][0], cfgs[p][1]);
      idle_push = (p != 2);
      idle_pop = (p != 2);
      for (int n = 0; n < 110; n++) send_word(rand_word());
    end
    push <= 1'b0;
    idle_push = 1'b1;
    idle_pop = 1'b1;
    while (pending_sums.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (n_errors == 0) begin
      $display("PASS conv2d_multichannel_mac_unit");
    end else begin
      $display("FAIL conv2d_multichannel_mac_unit");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL conv2d_multichannel_mac_unit");
    $finish;
  end

endmodule

>>> files.f
rtl/core/c2d_pkg.sv
rtl/core/c2d_ram.sv
rtl/core/c2d_front.sv
rtl/core/c2d_back.sv
rtl/core/conv2d_multichannel_mac_unit.sv
verif/conv2d_multichannel_mac_unit_tb.sv
